// ===== src/solar_to_lunar_date_unit_assert.svh =====
// Assertion macros used by the checker of the solar to lunar date unit.
`ifndef SOLAR_TO_LUNAR_DATE_UNIT_ASSERT_SVH
`define SOLAR_TO_LUNAR_DATE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define S2L_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("s2l checker: same-cycle property failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define S2L_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("s2l checker: next-cycle property failed");

`endif

// ===== src/s2l_pkg.sv =====
// Package with the year table, microcode and helper functions of the date unit.
`timescale 1ns / 1ps

package s2l_pkg;

  // Calendar constants.
  localparam int FIRST_YEAR         = 1900;
  localparam int LAST_ACCEPTED_YEAR = 2100;
  localparam int TABLE_LEN          = 201;
  // Start of the 400-year cycle that the day count is taken from.
  localparam int ERA_YEAR           = 1600;
  // Day count of 1900-01-31, the first lunar new year, in that same count.
  localparam int EPOCH_DAYS         = 109543;
  // Days in twelve 29-day months.
  localparam int BASE_YEAR_DAYS     = 348;

  // Field widths.
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 18;
  localparam int WORD_W  = 24;

  // Year words: bits 11:0 month sizes, 15:12 leap month, 16 leap month size.
  localparam logic [WORD_W-1:0] YEAR_WORDS [TABLE_LEN] = '{
    24'h7e8b52, 24'ha60752, 24'h900ea5, 24'h7a5b2a, 24'ha0064b, 24'h880a9b, 24'h734aa6, 24'h9a056a,
    24'h840b59, 24'h6c2ba8, 24'h940752, 24'h7c6d85, 24'ha40b25, 24'h8c0a4b, 24'h755a4b, 24'h9c02ad,
    24'h86056b, 24'h6e25b5, 24'h960da9, 24'h837e92, 24'ha80e92, 24'h900d25, 24'h785d2d, 24'ha00a56,
    24'h8a02b6, 24'h714ad5, 24'h9a06d4, 24'h840ea9, 24'h6e2f48, 24'h940e92, 24'h7c6686, 24'ha2052b,
    24'h8c0a57, 24'h755946, 24'h9c0b5a, 24'h8806d4, 24'h713761, 24'h960749, 24'h7f7b13, 24'ha60a93,
    24'h90052b, 24'h77651b, 24'h9e0aad, 24'h8a056a, 24'h734da5, 24'h9a0ba4, 24'h840b49, 24'h6c2d49,
    24'h940a95, 24'h7a7aad, 24'ha20536, 24'h8c0aad, 24'h775aca, 24'h9c05b2, 24'h860da5, 24'h713ea2,
    24'h980d4a, 24'h7e8515, 24'ha40a97, 24'h900556, 24'h786555, 24'h9e0ad5, 24'h8a06d2, 24'h724755,
    24'h9a0ea5, 24'h84064a, 24'h6a364b, 24'h920a9b, 24'h7c7a9a, 24'ha2056a, 24'h8c0b69, 24'h765ba2,
    24'h9e0b52, 24'h860b25, 24'h6e4b23, 24'h960a4b, 24'h7e8a2b, 24'ha402ad, 24'h8e056d, 24'h796589,
    24'ha00da9, 24'h8a0d92, 24'h724e95, 24'h9a0d25, 24'h84ac4d, 24'ha80a56, 24'h9202b6, 24'h7a62d5,
    24'ha206d5, 24'h8c0ea9, 24'h765f42, 24'h9e0e92, 24'h880d26, 24'h6e352a, 24'h940a57, 24'h7e8a56,
    24'ha6035a, 24'h8e06d5, 24'h785b69, 24'ha00749, 24'h8a0693, 24'h704a93, 24'h98052b, 24'h820a5b,
    24'h6c2aac, 24'h92056a, 24'h7a7d95, 24'ha40ba4, 24'h8e0b49, 24'h745d43, 24'h9c0a95, 24'h86052d,
    24'h6e4555, 24'h940ab5, 24'h7e9aaa, 24'ha605d2, 24'h900da5, 24'h796e8a, 24'ha00d4a, 24'h8a0c95,
    24'h724a96, 24'h980556, 24'h820ab5, 24'h6c2ad8, 24'h9406d2, 24'h7a6745, 24'ha20725, 24'h8c064b,
    24'h745647, 24'h9a0cab, 24'h86055a, 24'h6e356a, 24'h960b69, 24'h7ebb52, 24'ha60b52, 24'h900b25,
    24'h796d0b, 24'h9e0a4b, 24'h8804ab, 24'h7052ab, 24'h9805ad, 24'h820b6a, 24'h6c2da8, 24'h940d92,
    24'h7c7ea5, 24'ha20d25, 24'h8c0a55, 24'h755a4d, 24'h9c04b6, 24'h8405b5, 24'h6f36d2, 24'h960ec9,
    24'h828f12, 24'ha60e92, 24'h900d26, 24'h796516, 24'h9e0a57, 24'h880556, 24'h714365, 24'h980755,
    24'h840749, 24'h6a374b, 24'h920693, 24'h7a7aab, 24'ha2052b, 24'h8a0a5b, 24'h745aaa, 24'h9c056a,
    24'h860b65, 24'h6e4ba2, 24'h960b4a, 24'h7e8d15, 24'ha60a95, 24'h8e052d, 24'h76654d, 24'h9e0ab5,
    24'h8a05aa, 24'h7045d5, 24'h980da5, 24'h840d4a, 24'h6c3e49, 24'h920c96, 24'h7a7c8e, 24'ha20556,
    24'h8c0ab5, 24'h755ac2, 24'h9c06d2, 24'h860ea5, 24'h704722, 24'h94068b, 24'h7c8617, 24'ha404ab,
    24'h8e055b, 24'h776556, 24'h9e0b6a, 24'h8a0752, 24'h724b95, 24'h980b45, 24'h820a8b, 24'h6a2a4d,
    24'h9204ab
  };

  // Step addresses of the microcode.
  typedef logic [3:0] step_t;
  localparam step_t STEP_WAIT       = 4'd0;
  localparam step_t STEP_CHECK      = 4'd1;
  localparam step_t STEP_DAYS_A     = 4'd2;
  localparam step_t STEP_DAYS_B     = 4'd3;
  localparam step_t STEP_SIGN       = 4'd4;
  localparam step_t STEP_YEAR       = 4'd5;
  localparam step_t STEP_MONTH_INIT = 4'd6;
  localparam step_t STEP_MONTH      = 4'd7;
  localparam step_t STEP_LEAP       = 4'd8;
  localparam step_t STEP_DONE       = 4'd9;
  localparam step_t STEP_FAIL       = 4'd10;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_WAIT       = 4'd0,
    OP_CHECK      = 4'd1,
    OP_DAYS_A     = 4'd2,
    OP_DAYS_B     = 4'd3,
    OP_SIGN       = 4'd4,
    OP_YEAR       = 4'd5,
    OP_MONTH_INIT = 4'd6,
    OP_MONTH      = 4'd7,
    OP_LEAP       = 4'd8,
    OP_DONE       = 4'd9,
    OP_FAIL       = 4'd10
  } op_e;

  // One control word: operation, target when the step's test hits, target otherwise.
  typedef struct packed {
    op_e   op;
    step_t tgt_hit;
    step_t tgt_miss;
  } ctrl_t;

  // Microcode program.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    case (s)
      STEP_WAIT:       c = ctrl_t'{OP_WAIT,       STEP_CHECK,      STEP_WAIT};
      STEP_CHECK:      c = ctrl_t'{OP_CHECK,      STEP_FAIL,       STEP_DAYS_A};
      STEP_DAYS_A:     c = ctrl_t'{OP_DAYS_A,     STEP_DAYS_B,     STEP_DAYS_B};
      STEP_DAYS_B:     c = ctrl_t'{OP_DAYS_B,     STEP_SIGN,       STEP_SIGN};
      STEP_SIGN:       c = ctrl_t'{OP_SIGN,       STEP_FAIL,       STEP_YEAR};
      STEP_YEAR:       c = ctrl_t'{OP_YEAR,       STEP_MONTH_INIT, STEP_YEAR};
      STEP_MONTH_INIT: c = ctrl_t'{OP_MONTH_INIT, STEP_MONTH,      STEP_MONTH};
      STEP_MONTH:      c = ctrl_t'{OP_MONTH,      STEP_DONE,       STEP_LEAP};
      STEP_LEAP:       c = ctrl_t'{OP_LEAP,       STEP_DONE,       STEP_MONTH};
      STEP_DONE:       c = ctrl_t'{OP_DONE,       STEP_WAIT,       STEP_DONE};
      STEP_FAIL:       c = ctrl_t'{OP_FAIL,       STEP_WAIT,       STEP_FAIL};
      default:         c = ctrl_t'{OP_WAIT,       STEP_WAIT,       STEP_WAIT};
    endcase
    return c;
  endfunction

  // Day of the year counted from 1 March, for a month index with March as zero.
  function automatic logic [8:0] doy_of(logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Leap month number of a year word; codes above twelve mean no leap month.
  function automatic logic [3:0] leap_of(logic [WORD_W-1:0] w);
    logic [3:0] lm;
    lm = w[15:12];
    return (lm > 4'd12) ? 4'd0 : lm;
  endfunction

  // Number of days in the lunar year described by a year word.
  function automatic logic [8:0] year_len(logic [WORD_W-1:0] w);
    logic [8:0] sum;
    sum = 9'(BASE_YEAR_DAYS) + 9'($countones(w[11:0]));
    if (leap_of(w) != 4'd0) begin
      sum = sum + (w[16] ? 9'd30 : 9'd29);
    end
    return sum;
  endfunction

endpackage

// ===== src/s2l_if.sv =====
// Handshake interfaces carrying Gregorian date requests and lunar date results.
`timescale 1ns / 1ps

interface s2l_date_if;
  logic                         valid;
  logic                         ready;
  logic [s2l_pkg::YEAR_W-1:0]   solar_year;
  logic [s2l_pkg::MONTH_W-1:0]  solar_month;
  logic [s2l_pkg::DAY_W-1:0]    solar_day;

  modport source (output valid, output solar_year, output solar_month, output solar_day,
                  input ready);
  modport sink   (input valid, input solar_year, input solar_month, input solar_day,
                  output ready);
endinterface

interface s2l_lunar_if;
  logic                         valid;
  logic                         ready;
  logic [s2l_pkg::YEAR_W-1:0]   lunar_year_out;
  logic [s2l_pkg::MONTH_W-1:0]  lunar_month_out;
  logic [s2l_pkg::DAY_W-1:0]    lunar_day_out;
  logic                         leap_flag;
  logic                         valid_res;

  modport source (output valid, output lunar_year_out, output lunar_month_out,
                  output lunar_day_out, output leap_flag, output valid_res, input ready);
  modport sink   (input valid, input lunar_year_out, input lunar_month_out,
                  input lunar_day_out, input leap_flag, input valid_res, output ready);
endinterface

// ===== src/solar_to_lunar_date_unit.sv =====
// Top level of the Gregorian to Chinese lunar date converter.
// Usage: date_i takes one request (solar_year, solar_month, solar_day) with
// valid/ready; lunar_o returns one result per request with valid/ready.
// A microcoded sequencer steps through a short program in a constant table:
// it normalises the month, forms a day count from 1900-01-31 in two steps,
// then walks the year table one lunar year per cycle and then the months,
// each as a month step followed by a leap step (normal month, then the leap test).
// One request is in flight at a time; the next is taken in the cycle after the
// result is loaded into the output register, which may still be waiting.
// When the receiver stalls with a result pending, the sequencer holds its
// finished result until the output register frees.
// Reset clears the step counter to the wait step and the output valid.
`timescale 1ns / 1ps

module solar_to_lunar_date_unit #(
  parameter int YEAR_COUNT = 201
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  s2l_date_if.sink    date_i,
  s2l_lunar_if.source lunar_o
);

  localparam int Count     = (YEAR_COUNT < s2l_pkg::TABLE_LEN) ? YEAR_COUNT
                                                                : s2l_pkg::TABLE_LEN;
  localparam int LastRaw   = s2l_pkg::FIRST_YEAR + Count - 1;
  localparam int LastYear  = (LastRaw > s2l_pkg::LAST_ACCEPTED_YEAR)
                             ? s2l_pkg::LAST_ACCEPTED_YEAR : LastRaw;
  localparam int IdxW      = (Count > 1) ? $clog2(Count) : 1;
  localparam int OffW      = s2l_pkg::OFF_W;

  // Sequencer.
  s2l_pkg::step_t step_q, step_d;
  s2l_pkg::ctrl_t ctrl;
  logic           hit;
  logic           fail;

  // Request and working registers.
  logic [s2l_pkg::YEAR_W-1:0]  year_q, year_d;
  logic [s2l_pkg::MONTH_W-1:0] month_q, month_d;
  logic [s2l_pkg::DAY_W-1:0]   day_q, day_d;
  logic [8:0]                  t_q, t_d;
  logic [3:0]                  mp_q, mp_d;
  logic [18:0]                 acc_q, acc_d;
  logic [OffW-1:0]             offset_q, offset_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [s2l_pkg::WORD_W-1:0]  word_q, word_d;
  logic [3:0]                  mon_q, mon_d;
  logic                        leap_q, leap_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic [s2l_pkg::YEAR_W-1:0]  out_year_q;
  logic [s2l_pkg::MONTH_W-1:0] out_month_q;
  logic [s2l_pkg::DAY_W-1:0]   out_day_q;
  logic                        out_leap_q;
  logic                        out_res_q;
  logic                        out_free;
  logic                        load_ok;
  logic                        load_fail;

  // Helper values.
  logic                        in_range;
  logic [3:0]                  norm_month;
  logic [11:0]                 norm_year;
  logic [11:0]                 march_year;
  logic [2:0]                  q100;
  logic                        q400;
  logic [19:0]                 days_pos;
  logic [19:0]                 days_neg;
  logic [19:0]                 days_diff;
  logic [s2l_pkg::WORD_W-1:0]  cur_word;
  logic [8:0]                  cur_len;
  logic [11:0]                 mon_sizes;
  logic [4:0]                  mon_len;
  logic [4:0]                  leap_len;
  logic [3:0]                  leap_mon;
  logic                        at_leap;

  assign ctrl = s2l_pkg::ucode(step_q);

  // Year range check and month normalisation (month 0 and 13..15 roll the year).
  assign in_range = (year_q >= 12'(s2l_pkg::FIRST_YEAR)) && (year_q <= 12'(LastYear));
  always_comb begin
    if (month_q == 4'd0) begin
      norm_month = 4'd12;
      norm_year  = year_q - 12'd1;
    end else if (month_q > 4'd12) begin
      norm_month = month_q - 4'd12;
      norm_year  = year_q + 12'd1;
    end else begin
      norm_month = month_q;
      norm_year  = year_q;
    end
  end
  // Years counted from March, so that the leap day closes the year.
  assign march_year = (norm_month <= 4'd2) ? (norm_year - 12'd1) : norm_year;

  // Century corrections; within the accepted years t_q lies between 299 and 501.
  always_comb begin
    if (t_q >= 9'd500) begin
      q100 = 3'd5;
    end else if (t_q >= 9'd400) begin
      q100 = 3'd4;
    end else if (t_q >= 9'd300) begin
      q100 = 3'd3;
    end else begin
      q100 = 3'd2;
    end
  end
  assign q400      = (t_q >= 9'd400);
  assign days_pos  = 20'(acc_q) + 20'(q400) + 20'(s2l_pkg::doy_of(mp_q)) + 20'(day_q);
  assign days_neg  = 20'(q100) + 20'(s2l_pkg::EPOCH_DAYS) + 20'd1;
  assign days_diff = days_pos - days_neg;

  // Table read and month sizes.
  assign cur_word  = s2l_pkg::YEAR_WORDS[8'(idx_q)];
  assign cur_len   = s2l_pkg::year_len(cur_word);
  assign mon_sizes = word_q[11:0];
  assign mon_len   = mon_sizes[mon_q - 4'd1] ? 5'd30 : 5'd29;
  assign leap_len  = word_q[16] ? 5'd30 : 5'd29;
  assign leap_mon  = s2l_pkg::leap_of(word_q);
  assign at_leap   = (mon_q == leap_mon);

  assign out_free = !out_valid_q || lunar_o.ready;

  // Datapath operations and next step.
  always_comb begin
    hit      = 1'b0;
    fail     = 1'b0;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    t_d      = t_q;
    mp_d     = mp_q;
    acc_d    = acc_q;
    offset_d = offset_q;
    idx_d    = idx_q;
    word_d   = word_q;
    mon_d    = mon_q;
    leap_d   = leap_q;
    case (ctrl.op)
      s2l_pkg::OP_WAIT: begin
        hit = date_i.valid;
        if (date_i.valid) begin
          year_d  = date_i.solar_year;
          month_d = date_i.solar_month;
          day_d   = date_i.solar_day;
        end
      end
      s2l_pkg::OP_CHECK: begin
        hit  = !in_range;
        t_d  = 9'(march_year - 12'(s2l_pkg::ERA_YEAR));
        mp_d = (norm_month >= 4'd3) ? (norm_month - 4'd3) : (norm_month + 4'd9);
      end
      s2l_pkg::OP_DAYS_A: begin
        acc_d = 19'(t_q) * 19'd365 + 19'(t_q[8:2]);
      end
      s2l_pkg::OP_DAYS_B: begin
        offset_d = days_diff[OffW-1:0];
      end
      s2l_pkg::OP_SIGN: begin
        hit   = offset_q[OffW-1];
        idx_d = '0;
      end
      s2l_pkg::OP_YEAR: begin
        hit = (offset_q < OffW'(cur_len));
        if (!hit) begin
          offset_d = offset_q - OffW'(cur_len);
          idx_d    = idx_q + IdxW'(1);
          fail     = (idx_q == IdxW'(Count - 1));
        end
      end
      s2l_pkg::OP_MONTH_INIT: begin
        word_d = cur_word;
        mon_d  = 4'd1;
        leap_d = 1'b0;
      end
      s2l_pkg::OP_MONTH: begin
        hit = (offset_q < OffW'(mon_len));
        if (!hit) begin
          offset_d = offset_q - OffW'(mon_len);
        end
      end
      s2l_pkg::OP_LEAP: begin
        if (at_leap && (offset_q < OffW'(leap_len))) begin
          hit    = 1'b1;
          leap_d = 1'b1;
        end else begin
          if (at_leap) begin
            offset_d = offset_q - OffW'(leap_len);
          end
          mon_d = mon_q + 4'd1;
          fail  = (mon_q == 4'd12);
        end
      end
      s2l_pkg::OP_DONE: begin
        hit = out_free;
      end
      s2l_pkg::OP_FAIL: begin
        hit = out_free;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    if (fail) begin
      step_d = s2l_pkg::STEP_FAIL;
    end else if (hit) begin
      step_d = ctrl.tgt_hit;
    end else begin
      step_d = ctrl.tgt_miss;
    end
  end

  // Output register loads when the result step meets a free register.
  assign load_ok   = (ctrl.op == s2l_pkg::OP_DONE) && out_free;
  assign load_fail = (ctrl.op == s2l_pkg::OP_FAIL) && out_free;
  always_comb begin
    out_valid_d = out_valid_q && !lunar_o.ready;
    if (load_ok || load_fail) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= s2l_pkg::STEP_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    year_q   <= year_d;
    month_q  <= month_d;
    day_q    <= day_d;
    t_q      <= t_d;
    mp_q     <= mp_d;
    acc_q    <= acc_d;
    offset_q <= offset_d;
    idx_q    <= idx_d;
    word_q   <= word_d;
    mon_q    <= mon_d;
    leap_q   <= leap_d;
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      out_year_q  <= 12'(s2l_pkg::FIRST_YEAR) + 12'(idx_q);
      out_month_q <= mon_q;
      out_day_q   <= 5'(offset_q + OffW'(1));
      out_leap_q  <= leap_q;
      out_res_q   <= 1'b1;
    end else if (load_fail) begin
      out_year_q  <= '0;
      out_month_q <= '0;
      out_day_q   <= '0;
      out_leap_q  <= 1'b0;
      out_res_q   <= 1'b0;
    end
  end

  assign date_i.ready           = (ctrl.op == s2l_pkg::OP_WAIT);
  assign lunar_o.valid          = out_valid_q;
  assign lunar_o.lunar_year_out = out_year_q;
  assign lunar_o.lunar_month_out = out_month_q;
  assign lunar_o.lunar_day_out  = out_day_q;
  assign lunar_o.leap_flag      = out_leap_q;
  assign lunar_o.valid_res      = out_res_q;

endmodule

// ===== src/s2l_checker.sv =====
// Port-level checker for the date unit, bound to its top level.
`timescale 1ns / 1ps
`include "solar_to_lunar_date_unit_assert.svh"

module s2l_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [11:0] lunar_year_i,
  input logic [3:0]  lunar_month_i,
  input logic [4:0]  lunar_day_i,
  input logic        leap_flag_i,
  input logic        valid_res_i
);

  logic [22:0] res_bits;
  logic        month_ok;
  logic        day_ok;

  // Whole result payload and the lunar bounds of its month and day.
  assign res_bits = {lunar_year_i, lunar_month_i, lunar_day_i, leap_flag_i, valid_res_i};
  assign month_ok = (lunar_month_i >= 4'd1) && (lunar_month_i <= 4'd12);
  assign day_ok   = (lunar_day_i >= 5'd1) && (lunar_day_i <= 5'd30);

  // A stalled result stays offered and unchanged.
  `S2L_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(res_bits))

  // Only one request is worked on at a time.
  `S2L_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i)

  // A date outside the table gives an all-zero result.
  `S2L_ASSERT_NOW(a_invalid_zero, out_valid_i && !valid_res_i, res_bits == 23'd0)

  // A covered date has a month and day within lunar bounds.
  `S2L_ASSERT_NOW(a_valid_bounds, out_valid_i && valid_res_i, month_ok && day_ok)

endmodule

bind solar_to_lunar_date_unit s2l_checker u_s2l_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (date_i.valid),
  .in_ready_i    (date_i.ready),
  .out_valid_i   (lunar_o.valid),
  .out_ready_i   (lunar_o.ready),
  .lunar_year_i  (lunar_o.lunar_year_out),
  .lunar_month_i (lunar_o.lunar_month_out),
  .lunar_day_i   (lunar_o.lunar_day_out),
  .leap_flag_i   (lunar_o.leap_flag),
  .valid_res_i   (lunar_o.valid_res)
);

// ===== tb/sv/tb_solar_to_lunar_date_unit.sv =====
// Self-checking testbench for the Gregorian to Chinese lunar date converter.
`timescale 1ns / 1ps

module tb_solar_to_lunar_date_unit;

  localparam int YEAR_W        = s2l_pkg::YEAR_W;
  localparam int MONTH_W       = s2l_pkg::MONTH_W;
  localparam int DAY_W         = s2l_pkg::DAY_W;

  localparam int CLK_PERIOD    = 12;
  localparam int BASE_YEAR     = 1900;
  localparam int TOP_YEAR      = 2100;
  localparam int CODE_COUNT    = 201;
  localparam int RANDOM_DATES  = 626;
  localparam int DRAIN_CYCLES  = 300;
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } solar_date_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               leap;
    logic               ok;
  } lunar_date_t;

  typedef struct packed {
    solar_date_t req;
    logic        typed;
    lunar_date_t want;
  } directed_row_t;

  localparam lunar_date_t NO_LUNAR_DATE = '0;

  // Lunar year codes: bits 11:0 month sizes, 15:12 leap month, 16 leap month size.
  localparam bit [23:0] LUNAR_YEAR_CODES [CODE_COUNT] = '{
    24'h7e8b52, 24'ha60752, 24'h900ea5, 24'h7a5b2a, 24'ha0064b, 24'h880a9b, 24'h734aa6, 24'h9a056a,
    24'h840b59, 24'h6c2ba8, 24'h940752, 24'h7c6d85, 24'ha40b25, 24'h8c0a4b, 24'h755a4b, 24'h9c02ad,
    24'h86056b, 24'h6e25b5, 24'h960da9, 24'h837e92, 24'ha80e92, 24'h900d25, 24'h785d2d, 24'ha00a56,
    24'h8a02b6, 24'h714ad5, 24'h9a06d4, 24'h840ea9, 24'h6e2f48, 24'h940e92, 24'h7c6686, 24'ha2052b,
    24'h8c0a57, 24'h755946, 24'h9c0b5a, 24'h8806d4, 24'h713761, 24'h960749, 24'h7f7b13, 24'ha60a93,
    24'h90052b, 24'h77651b, 24'h9e0aad, 24'h8a056a, 24'h734da5, 24'h9a0ba4, 24'h840b49, 24'h6c2d49,
    24'h940a95, 24'h7a7aad, 24'ha20536, 24'h8c0aad, 24'h775aca, 24'h9c05b2, 24'h860da5, 24'h713ea2,
    24'h980d4a, 24'h7e8515, 24'ha40a97, 24'h900556, 24'h786555, 24'h9e0ad5, 24'h8a06d2, 24'h724755,
    24'h9a0ea5, 24'h84064a, 24'h6a364b, 24'h920a9b, 24'h7c7a9a, 24'ha2056a, 24'h8c0b69, 24'h765ba2,
    24'h9e0b52, 24'h860b25, 24'h6e4b23, 24'h960a4b, 24'h7e8a2b, 24'ha402ad, 24'h8e056d, 24'h796589,
    24'ha00da9, 24'h8a0d92, 24'h724e95, 24'h9a0d25, 24'h84ac4d, 24'ha80a56, 24'h9202b6, 24'h7a62d5,
    24'ha206d5, 24'h8c0ea9, 24'h765f42, 24'h9e0e92, 24'h880d26, 24'h6e352a, 24'h940a57, 24'h7e8a56,
    24'ha6035a, 24'h8e06d5, 24'h785b69, 24'ha00749, 24'h8a0693, 24'h704a93, 24'h98052b, 24'h820a5b,
    24'h6c2aac, 24'h92056a, 24'h7a7d95, 24'ha40ba4, 24'h8e0b49, 24'h745d43, 24'h9c0a95, 24'h86052d,
    24'h6e4555, 24'h940ab5, 24'h7e9aaa, 24'ha605d2, 24'h900da5, 24'h796e8a, 24'ha00d4a, 24'h8a0c95,
    24'h724a96, 24'h980556, 24'h820ab5, 24'h6c2ad8, 24'h9406d2, 24'h7a6745, 24'ha20725, 24'h8c064b,
    24'h745647, 24'h9a0cab, 24'h86055a, 24'h6e356a, 24'h960b69, 24'h7ebb52, 24'ha60b52, 24'h900b25,
    24'h796d0b, 24'h9e0a4b, 24'h8804ab, 24'h7052ab, 24'h9805ad, 24'h820b6a, 24'h6c2da8, 24'h940d92,
    24'h7c7ea5, 24'ha20d25, 24'h8c0a55, 24'h755a4d, 24'h9c04b6, 24'h8405b5, 24'h6f36d2, 24'h960ec9,
    24'h828f12, 24'ha60e92, 24'h900d26, 24'h796516, 24'h9e0a57, 24'h880556, 24'h714365, 24'h980755,
    24'h840749, 24'h6a374b, 24'h920693, 24'h7a7aab, 24'ha2052b, 24'h8a0a5b, 24'h745aaa, 24'h9c056a,
    24'h860b65, 24'h6e4ba2, 24'h960b4a, 24'h7e8d15, 24'ha60a95, 24'h8e052d, 24'h76654d, 24'h9e0ab5,
    24'h8a05aa, 24'h7045d5, 24'h980da5, 24'h840d4a, 24'h6c3e49, 24'h920c96, 24'h7a7c8e, 24'ha20556,
    24'h8c0ab5, 24'h755ac2, 24'h9c06d2, 24'h860ea5, 24'h704722, 24'h94068b, 24'h7c8617, 24'ha404ab,
    24'h8e055b, 24'h776556, 24'h9e0b6a, 24'h8a0752, 24'h724b95, 24'h980b45, 24'h820a8b, 24'h6a2a4d,
    24'h9204ab
  };

  // Directed requests; the expected date is typed in only where typed is set.
  localparam directed_row_t DIRECTED_ROWS [24] = '{
    '{{12'd0,    4'd1,  5'd1},  1'b1, NO_LUNAR_DATE},
    '{{12'd4095, 4'd15, 5'd31}, 1'b1, NO_LUNAR_DATE},
    '{{12'd1899, 4'd12, 5'd31}, 1'b1, NO_LUNAR_DATE},
    '{{12'd2101, 4'd1,  5'd1},  1'b1, NO_LUNAR_DATE},
    '{{12'd1900, 4'd1,  5'd30}, 1'b1, NO_LUNAR_DATE},
    '{{12'd1900, 4'd1,  5'd0},  1'b1, NO_LUNAR_DATE},
    '{{12'd1900, 4'd0,  5'd15}, 1'b1, NO_LUNAR_DATE},
    '{{12'd1900, 4'd1,  5'd31}, 1'b1, {12'd1900, 4'd1, 5'd1, 1'b0, 1'b1}},
    '{{12'd1900, 4'd2,  5'd1},  1'b0, NO_LUNAR_DATE},
    '{{12'd1900, 4'd10, 5'd10}, 1'b0, NO_LUNAR_DATE},
    '{{12'd2020, 4'd6,  5'd1},  1'b0, NO_LUNAR_DATE},
    '{{12'd2023, 4'd4,  5'd1},  1'b0, NO_LUNAR_DATE},
    '{{12'd2100, 4'd12, 5'd31}, 1'b0, NO_LUNAR_DATE},
    '{{12'd2100, 4'd15, 5'd31}, 1'b0, NO_LUNAR_DATE},
    '{{12'd2100, 4'd13, 5'd1},  1'b0, NO_LUNAR_DATE},
    '{{12'd2000, 4'd2,  5'd31}, 1'b0, NO_LUNAR_DATE},
    '{{12'd2000, 4'd3,  5'd0},  1'b0, NO_LUNAR_DATE},
    '{{12'd1999, 4'd12, 5'd31}, 1'b0, NO_LUNAR_DATE},
    '{{12'd2000, 4'd0,  5'd1},  1'b0, NO_LUNAR_DATE},
    '{{12'd2024, 4'd2,  5'd29}, 1'b0, NO_LUNAR_DATE},
    '{{12'd2023, 4'd2,  5'd29}, 1'b0, NO_LUNAR_DATE},
    '{{12'd1984, 4'd2,  5'd2},  1'b0, NO_LUNAR_DATE},
    '{{12'd2000, 4'd15, 5'd0},  1'b0, NO_LUNAR_DATE},
    '{{12'd2100, 4'd0,  5'd0},  1'b0, NO_LUNAR_DATE}
  };

  logic clk_i;
  logic rst_ni;

  s2l_date_if  date_if ();
  s2l_lunar_if lunar_if ();

  solar_to_lunar_date_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .date_i  (date_if),
    .lunar_o (lunar_if)
  );

  lunar_date_t pending_lunar[$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  bit          gapless     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Day count of a Gregorian date; month days beyond the month's end simply run on.
  function automatic int gregorian_day_number(int y, int m, int d);
    int before_month [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int py;
    bit leap_year;
    py = y - 1;
    leap_year = ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    return py * 365 + py / 4 - py / 100 + py / 400 + before_month[4'(m - 1)]
           + ((leap_year && m > 2) ? 1 : 0) + d;
  endfunction

  // Leap month of a year code; codes above twelve mean there is none.
  function automatic int intercalary_month(bit [23:0] code);
    return (code[15:12] > 4'd12) ? 0 : int'(code[15:12]);
  endfunction

  // Lunar date that a Gregorian request should convert to.
  function automatic lunar_date_t predict_lunar(solar_date_t req);
    lunar_date_t res;
    bit [23:0]   code;
    int          y;
    int          mo;
    int          offset;
    int          idx;
    int          m;
    int          span;
    bit          in_leap;
    res = NO_LUNAR_DATE;
    in_leap = 1'b0;
    y = int'(req.year);
    mo = int'(req.month);
    if (y < BASE_YEAR || y > TOP_YEAR) return res;
    // Month zero belongs to the year before, months past twelve to the year after.
    if (mo == 0) begin
      mo = 12;
      y = y - 1;
    end else if (mo > 12) begin
      mo = mo - 12;
      y = y + 1;
    end
    offset = gregorian_day_number(y, mo, int'(req.day)) - gregorian_day_number(BASE_YEAR, 1, 31);
    if (offset < 0) return res;
    // Skip whole lunar years.
    for (idx = 0; idx < CODE_COUNT; idx++) begin
      code = LUNAR_YEAR_CODES[8'(idx)];
      span = 348 + $countones(code[11:0]);
      if (intercalary_month(code) != 0) span = span + (code[16] ? 30 : 29);
      if (offset < span) break;
      offset = offset - span;
    end
    if (idx == CODE_COUNT) return res;
    // Skip whole months; the leap month follows its normal month.
    code = LUNAR_YEAR_CODES[8'(idx)];
    for (m = 1; m <= 12; m++) begin
      span = code[5'(m - 1)] ? 30 : 29;
      if (offset < span) break;
      offset = offset - span;
      if (m == intercalary_month(code)) begin
        span = code[16] ? 30 : 29;
        if (offset < span) begin
          in_leap = 1'b1;
          break;
        end
        offset = offset - span;
      end
    end
    res.year  = YEAR_W'(BASE_YEAR + idx);
    res.month = MONTH_W'(m);
    res.day   = DAY_W'(offset + 1);
    res.leap  = in_leap;
    res.ok    = 1'b1;
    return res;
  endfunction

  function automatic int unsigned draw_wait();
    return gapless ? 0 : $urandom_range(9);
  endfunction

  // Mostly well-formed dates in the covered years, plus overflow and noise.
  function automatic solar_date_t draw_solar_date();
    solar_date_t req;
    req.year  = YEAR_W'($urandom_range(TOP_YEAR, BASE_YEAR));
    req.month = MONTH_W'($urandom_range(12, 1));
    req.day   = DAY_W'($urandom_range(28, 1));
    case ($urandom_range(9))
      0: begin
        req.year  = YEAR_W'($urandom);
        req.month = MONTH_W'($urandom);
        req.day   = DAY_W'($urandom);
      end
      1: begin
        req.month = MONTH_W'($urandom);
        req.day   = DAY_W'($urandom);
      end
      2, 3: begin
        // Around the lunar new year.
        req.month = MONTH_W'($urandom_range(2, 1));
        req.day   = DAY_W'($urandom_range(31, 1));
      end
      default: ;
    endcase
    return req;
  endfunction

  // Offers one request and records its expected result once it is taken.
  task automatic send_date(input solar_date_t req, input bit typed, input lunar_date_t want);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      date_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    date_if.valid       <= 1'b1;
    date_if.solar_year  <= req.year;
    date_if.solar_month <= req.month;
    date_if.solar_day   <= req.day;
    do @(posedge clk_i); while (date_if.ready !== 1'b1);
    pending_lunar.push_back(typed ? want : predict_lunar(req));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    while (pending_lunar.size() != 0) @(negedge clk_i);
  endtask

  // Result side: random back-pressure, each result checked against the oldest expectation.
  initial begin : lunar_sink
    int unsigned stall;
    lunar_date_t got;
    lunar_date_t want;
    lunar_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        lunar_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      lunar_if.ready <= 1'b1;
      do @(posedge clk_i); while (lunar_if.valid !== 1'b1);
      got = {lunar_if.lunar_year_out, lunar_if.lunar_month_out, lunar_if.lunar_day_out,
             lunar_if.leap_flag, lunar_if.valid_res};
      if (pending_lunar.size() == 0) begin
        $error("lunar result with no request outstanding");
        mismatches++;
      end else begin
        want = pending_lunar.pop_front();
        if (got.year !== want.year) begin
          $error("lunar_year_out: expected %0d, got %0d", want.year, got.year);
          mismatches++;
        end
        if (got.month !== want.month) begin
          $error("lunar_month_out: expected %0d, got %0d", want.month, got.month);
          mismatches++;
        end
        if (got.day !== want.day) begin
          $error("lunar_day_out: expected %0d, got %0d", want.day, got.day);
          mismatches++;
        end
        if (got.leap !== want.leap) begin
          $error("leap_flag: expected %0d, got %0d", want.leap, got.leap);
          mismatches++;
        end
        if (got.ok !== want.ok) begin
          $error("valid_res: expected %0d, got %0d", want.ok, got.ok);
          mismatches++;
        end
      end
      @(negedge clk_i);
    end
  end

  // Watchdog: too long without any request or result being taken.
  always @(posedge clk_i) begin
    if (!rst_ni || (date_if.valid && date_if.ready) || (lunar_if.valid && lunar_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("solar_to_lunar_date_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Request side: reset, directed table, then random dates.
  initial begin : date_source
    date_if.valid       = 1'b0;
    date_if.solar_year  = '0;
    date_if.solar_month = '0;
    date_if.solar_day   = '0;
    rst_ni              = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      send_date(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end
    date_if.valid <= 1'b0;
    drain_results();

    for (int n = 0; n < RANDOM_DATES; n++) begin
      // Switch at random between stretches with and without idle cycles.
      if (n % 50 == 0) gapless = ($urandom_range(3) == 0);
      // Hold off once midway until every outstanding result is back.
      if (n == RANDOM_DATES / 2) begin
        date_if.valid <= 1'b0;
        drain_results();
      end
      send_date(draw_solar_date(), 1'b0, NO_LUNAR_DATE);
    end
    date_if.valid <= 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("solar_to_lunar_date_unit test passed");
    end else begin
      $display("solar_to_lunar_date_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/s2l_pkg.sv
src/s2l_if.sv
src/solar_to_lunar_date_unit.sv
src/s2l_checker.sv
tb/sv/tb_solar_to_lunar_date_unit.sv
